/* src/knps_pkg.sv */
package knps_pkg;

  // field widths fixed by the interface
  localparam int COORD_W  = 24;
  localparam int ID_W     = 16;
  localparam int KEY_W    = 64;
  localparam int DIST_W   = 2 * COORD_W + 1;
  localparam int RANK_W   = 4;
  localparam int CNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // most results sent per run
  localparam logic [CNT_W-1:0] MAX_EMIT = CNT_W'(16);
  localparam logic [CNT_W-1:0] RESULTS_RESET = CNT_W'(16);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESULTS_WANTED = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]          point_id;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [KEY_W-1:0]         name_key;
    logic                     final_item;
  } in_word_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   chosen_id;
    logic [DIST_W-1:0] dist_sq;
    logic              end_of_run;
  } out_word_t;

  // one list entry
  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   id;
    logic [KEY_W-1:0]  key;
  } entry_t;

  // candidate leaving the distance pipeline
  typedef struct packed {
    logic   valid;
    logic   final_item;
    entry_t entry;
  } cand_t;

  // per-cycle command to every cell
  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_t;

endpackage

/* src/knps_dist.sv */
module knps_dist (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  knps_pkg::in_word_t                     word,
  input  logic signed [knps_pkg::COORD_W-1:0]    target_x,
  input  logic signed [knps_pkg::COORD_W-1:0]    target_y,
  output knps_pkg::cand_t                        cand,
  output logic                                   final_pending
);

  localparam int CW = knps_pkg::COORD_W;

  // stage 1: absolute coordinate differences
  logic              s1_valid;
  logic              s1_final;
  logic [CW-1:0]     s1_dx;
  logic [CW-1:0]     s1_dy;
  logic [knps_pkg::ID_W-1:0]  s1_id;
  logic [knps_pkg::KEY_W-1:0] s1_key;

  // stage 2: squares
  logic              s2_valid;
  logic              s2_final;
  logic [2*CW-1:0]   s2_sx;
  logic [2*CW-1:0]   s2_sy;
  logic [knps_pkg::ID_W-1:0]  s2_id;
  logic [knps_pkg::KEY_W-1:0] s2_key;

  // stage 3: distance sum
  logic              s3_valid;
  logic              s3_final;
  logic [knps_pkg::DIST_W-1:0] s3_dist;
  logic [knps_pkg::ID_W-1:0]   s3_id;
  logic [knps_pkg::KEY_W-1:0]  s3_key;

  logic signed [CW:0] diff_x;
  logic signed [CW:0] diff_y;
  logic [CW:0]        mag_x;
  logic [CW:0]        mag_y;

  // one extra bit holds the full difference range
  always_comb begin
    diff_x = {word.pos_x[CW-1], word.pos_x} - {target_x[CW-1], target_x};
    diff_y = {word.pos_y[CW-1], word.pos_y} - {target_y[CW-1], target_y};
    mag_x  = diff_x[CW] ? -diff_x : diff_x;
    mag_y  = diff_y[CW] ? -diff_y : diff_y;
  end

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= load;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // stage data
  always_ff @(posedge clk) begin
    s1_dx    <= mag_x[CW-1:0];
    s1_dy    <= mag_y[CW-1:0];
    s1_id    <= word.point_id;
    s1_key   <= word.name_key;
    s1_final <= word.final_item;

    s2_sx    <= s1_dx * s1_dx;
    s2_sy    <= s1_dy * s1_dy;
    s2_id    <= s1_id;
    s2_key   <= s1_key;
    s2_final <= s1_final;

    s3_dist  <= {1'b0, s2_sx} + {1'b0, s2_sy};
    s3_id    <= s2_id;
    s3_key   <= s2_key;
    s3_final <= s2_final;
  end

  assign cand.valid         = s3_valid;
  assign cand.final_item    = s3_final;
  assign cand.entry.sq_dist = s3_dist;
  assign cand.entry.id      = s3_id;
  assign cand.entry.key     = s3_key;

  // a run end still on its way to the list
  assign final_pending = (s1_valid && s1_final) || (s2_valid && s2_final)
                      || (s3_valid && s3_final);

endmodule

/* src/knps_cell.sv */
module knps_cell (
  input  logic                 clk,
  input  knps_pkg::cell_ctrl_t ctrl,
  input  knps_pkg::entry_t     cand,
  input  logic                 occupied,
  input  logic                 prev_ahead,
  input  knps_pkg::entry_t     prev_entry,
  input  knps_pkg::entry_t     next_entry,
  output knps_pkg::entry_t     entry,
  output logic                 ahead
);

  knps_pkg::entry_t held;

  // candidate sorts strictly ahead of this cell's entry
  always_comb begin
    ahead = !occupied
         || (cand.sq_dist < held.sq_dist)
         || ((cand.sq_dist == held.sq_dist) && (cand.key < held.key));
  end

  // shift toward the head when reading out, else insert
  always_ff @(posedge clk) begin
    if (ctrl.shift_out) begin
      held <= next_entry;
    end else if (ctrl.insert && ahead) begin
      held <= prev_ahead ? prev_entry : cand;
    end
  end

  assign entry = held;

endmodule

/* src/k_nearest_point_select_unit.sv */
// k-nearest point selection.
// Input channel (in_valid/in_stall/in_word): one candidate point per word,
// with id, Q12.12 coordinates, a name key and a final_item flag.
// Configuration (cfg_we/cfg_index/cfg_data): query point x, y and the
// number of results wanted; the user must write them only between runs,
// as the block does not enforce it. Each candidate passes a 3-stage
// distance pipeline (difference, square, sum) and is then inserted into a
// chain of K_BEST cells kept sorted by squared distance, then name key;
// one candidate is accepted per cycle while a run is filling.
// When the final word of a run is accepted, in_stall goes high. Once that
// candidate has passed the pipeline into the list, the leading entries are
// read out from the head cell one per cycle, unless the output stalls, as
// the cells shift forward. Results come out on out_valid/out_stall/out_word,
// and a stall on the output holds the output register and freezes the
// readout. After the last result is loaded the list is emptied and input
// is taken again.
// Reset empties the list and restores the query point to 0 and the
// results wanted to 16; stored entries need no clearing.
module k_nearest_point_select_unit #(
  parameter int K_BEST = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  knps_pkg::in_word_t                     in_word,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output knps_pkg::out_word_t                    out_word,
  input  logic                                   cfg_we,
  input  logic [knps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [knps_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int FW    = $clog2(K_BEST + 1);
  localparam int CMP_W = (FW > knps_pkg::CNT_W) ? FW : knps_pkg::CNT_W;
  localparam int CW    = knps_pkg::COORD_W;

  logic signed [CW-1:0]          target_x;
  logic signed [CW-1:0]          target_y;
  logic [knps_pkg::CNT_W-1:0]    results_wanted;

  knps_pkg::state_t              state;
  knps_pkg::state_t              state_next;
  logic [FW-1:0]                 fill;
  logic [FW-1:0]                 fill_next;
  logic [knps_pkg::CNT_W-1:0]    emit_idx;
  logic [knps_pkg::CNT_W-1:0]    emit_idx_next;
  logic [knps_pkg::CNT_W-1:0]    emit_limit;
  logic [knps_pkg::CNT_W-1:0]    emit_count;
  logic                          emit_load;

  knps_pkg::cand_t               cand;
  logic                          final_pending;
  logic                          in_take;
  knps_pkg::cell_ctrl_t          ctrl;

  knps_pkg::entry_t              cell_entry [K_BEST];
  logic                          cell_before [K_BEST];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x       <= '0;
      target_y       <= '0;
      results_wanted <= knps_pkg::RESULTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        knps_pkg::REG_TARGET_X:       target_x <= cfg_data[CW-1:0];
        knps_pkg::REG_TARGET_Y:       target_y <= cfg_data[CW-1:0];
        knps_pkg::REG_RESULTS_WANTED: results_wanted <= cfg_data[knps_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input is held off from a run end until the list is emptied
  assign in_stall = (state == knps_pkg::ST_EMIT) || final_pending;
  assign in_take  = in_valid && !in_stall;

  knps_dist u_dist (
    .clk           (clk),
    .rst           (rst),
    .load          (in_take),
    .word          (in_word),
    .target_x      (target_x),
    .target_y      (target_y),
    .cand          (cand),
    .final_pending (final_pending)
  );

  // number of results for this run
  always_comb begin
    emit_limit = (results_wanted > knps_pkg::MAX_EMIT) ? knps_pkg::MAX_EMIT
                                                       : results_wanted;
    emit_count = (CMP_W'(fill) < CMP_W'(emit_limit)) ? knps_pkg::CNT_W'(fill)
                                                     : emit_limit;
  end

  // run control
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    emit_idx_next = emit_idx;
    emit_load     = 1'b0;
    ctrl.insert    = 1'b0;
    ctrl.shift_out = 1'b0;
    unique case (state)
      knps_pkg::ST_FILL: begin
        if (cand.valid) begin
          ctrl.insert = 1'b1;
          if (fill != FW'(K_BEST)) begin
            fill_next = fill + FW'(1);
          end
          if (cand.final_item) begin
            state_next    = knps_pkg::ST_EMIT;
            emit_idx_next = '0;
          end
        end
      end
      knps_pkg::ST_EMIT: begin
        if (emit_idx == emit_count) begin
          fill_next  = '0;
          state_next = knps_pkg::ST_FILL;
        end else if (!out_valid || !out_stall) begin
          emit_load      = 1'b1;
          ctrl.shift_out = 1'b1;
          emit_idx_next  = emit_idx + knps_pkg::CNT_W'(1);
        end
      end
      default: state_next = knps_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= knps_pkg::ST_FILL;
      fill     <= '0;
      emit_idx <= '0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      emit_idx <= emit_idx_next;
    end
  end

  // sorted chain of cells, head at index 0
  genvar g;
  generate
    for (g = 0; g < K_BEST; g++) begin : g_cell
      knps_pkg::entry_t prev_entry;
      knps_pkg::entry_t next_entry;
      logic             prev_before;

      if (g == 0) begin : g_head
        assign prev_entry  = cand.entry;
        assign prev_before = 1'b0;
      end else begin : g_body
        assign prev_entry  = cell_entry[g-1];
        assign prev_before = cell_before[g-1];
      end

      if (g == K_BEST - 1) begin : g_tail
        assign next_entry = cell_entry[g];
      end else begin : g_inner
        assign next_entry = cell_entry[g+1];
      end

      knps_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .cand        (cand.entry),
        .occupied    (fill > FW'(g)),
        .prev_ahead  (prev_before),
        .prev_entry  (prev_entry),
        .next_entry  (next_entry),
        .entry       (cell_entry[g]),
        .ahead       (cell_before[g])
      );
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word.rank       <= emit_idx[knps_pkg::RANK_W-1:0];
      out_word.chosen_id  <= cell_entry[0].id;
      out_word.dist_sq    <= cell_entry[0].sq_dist;
      out_word.end_of_run <= (emit_idx + knps_pkg::CNT_W'(1)) == emit_count;
    end
  end

endmodule
